@@ sv/rvae_pkg.sv @@
`timescale 1ns / 1ps

package rvae_pkg;

    // Carrier phase accumulator and quarter-wave sine table geometry.
    localparam int PHASE_BITS  = 24;
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_ABITS  = $clog2(SINE_DEPTH);

    // Sample and configuration widths.
    localparam int SAMPLE_W    = 16;
    localparam int STEP_W      = 24;
    localparam int CRUSH_W     = 5;
    localparam int COEF_W      = 19;
    localparam int HIST_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Datapath widths of the bit-serial multipliers.
    localparam int RING_W      = 31;
    localparam int RING_BITS   = 16;
    localparam int DIFF_BITS   = SAMPLE_W + 1;
    localparam int MUL_W       = HIST_W;
    localparam int CNT_W       = $clog2(MUL_W + 1);
    localparam int ACC_W       = 48;

    // Bit depth limits of the crusher.
    localparam logic [CRUSH_W-1:0] CRUSH_MIN = CRUSH_W'(4);
    localparam logic [CRUSH_W-1:0] CRUSH_MAX = CRUSH_W'(16);

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]  RST_PHASE_STEP = STEP_W'(209715);
    localparam logic               RST_SQUARE     = 1'b1;
    localparam logic [CRUSH_W-1:0] RST_CRUSH_BITS = CRUSH_W'(8);
    localparam logic               RST_BYPASS     = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP = 3'd0,
        CFG_SQUARE     = 3'd1,
        CFG_CRUSH_BITS = 3'd2,
        CFG_COEF_B0    = 3'd3,
        CFG_COEF_A1    = 3'd4,
        CFG_COEF_A2    = 3'd5,
        CFG_BYPASS     = 3'd6
    } cfg_index_t;

    typedef logic [SAMPLE_W-1:0] sine_rom_t [0:SINE_DEPTH];

    // Restoring long division, used only while building the table.
    function automatic longint unsigned div_shift_sub(longint unsigned num,
                                                      longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine, entry k = sin(pi/2 * k / SINE_DEPTH) scaled by 32768.
    // Built from a nine-term Taylor series in Q30 while elaborating.
    function automatic sine_rom_t build_sine();
        sine_rom_t         rom;
        longint unsigned   theta;
        longint unsigned   term;
        longint            sum;
        longint            val;
        longint unsigned   half_pi_q30;
        half_pi_q30 = 64'd1686629713;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            theta = (half_pi_q30 * longint'(k)) >> SINE_ABITS;
            term  = theta;
            sum   = longint'(theta);
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * theta) >> 30;
                term = (term * theta) >> 30;
                term = div_shift_sub(term, 64'((2 * n) * (2 * n + 1)));
                if ((n % 2) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            val = (sum + 16384) >>> 15;
            if (val > 32768)
            begin
                val = 32768;
            end
            rom[k] = SAMPLE_W'(val);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

endpackage

@@ sv/robot_voice_audio_effect_top.sv @@
`timescale 1ns / 1ps

// Robot-voice effect for Q1.15 audio: each input sample is ring-modulated by a
// sine or square carrier from a 24-bit phase accumulator, crushed to a
// programmable bit depth with rounding half away from zero, and filtered by a
// biquad bandpass (b1 = 0, b2 = -b0) whose 24-bit history saturates; the
// output is saturated to 16 bits. One result is returned for every sample, in
// order. With bypass set a sample passes unchanged through the result
// register to the output register, and neither the carrier phase nor the
// filter history moves.
// With the effect enabled a sample passes through the sine table read, the
// ring product, the crusher, the loading and running of each filter product
// and the final rounding before it reaches the result register: every
// multiplication runs bit-serially, one multiplier bit per clock, over the
// 16-bit ring product and the 17-, 24- and 24-bit filter products. A new
// sample is taken as soon as the previous one has reached the output
// register, even if that result has not yet been taken downstream.
// Configuration registers are written over a separate valid/ready channel
// that is always ready; any write to a defined register index clears the
// filter history but keeps the carrier phase, and writes to an undefined index
// are ignored. Software supplies the filter coefficients and phase step
// precomputed and in range.

module robot_voice_audio_effect_top
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rvae_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [15:0] sample_in

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rvae_pkg::SAMPLE_W-1:0]       m_axis_tdata,   // [15:0] sample_out

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rvae_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rvae_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CARRIER,
        ST_LOAD_RING,
        ST_RING,
        ST_CRUSH,
        ST_LOAD_MAC,
        ST_MAC,
        ST_ROUND,
        ST_DONE
    } state_t;

    localparam int SW = rvae_pkg::SAMPLE_W;
    localparam int AW = rvae_pkg::ACC_W;
    localparam int HW = rvae_pkg::HIST_W;

    localparam logic signed [AW-1:0] ROUND_HALF = AW'(32768);
    localparam logic signed [AW-1:0] HIST_MAX   = AW'((1 << (HW - 1)) - 1);
    localparam logic signed [AW-1:0] HIST_MIN   = -AW'(1 << (HW - 1));
    localparam logic signed [HW-1:0] OUT_MAX    = HW'((1 << (SW - 1)) - 1);
    localparam logic signed [HW-1:0] OUT_MIN    = -HW'(1 << (SW - 1));
    localparam logic [SW-1:0]        FULL_SCALE = SW'(1 << (SW - 1));

    // Configuration registers.
    logic [rvae_pkg::STEP_W-1:0]        phase_step_reg;
    logic                               square_reg;
    logic [rvae_pkg::CRUSH_W-1:0]       crush_bits_reg;
    logic signed [rvae_pkg::COEF_W-1:0] coef_b0_reg;
    logic signed [rvae_pkg::COEF_W-1:0] coef_a1_reg;
    logic signed [rvae_pkg::COEF_W-1:0] coef_a2_reg;
    logic                               bypass_reg;

    // Sample state.
    logic [rvae_pkg::PHASE_BITS-1:0]    phase_reg;
    logic signed [SW-1:0]               crushed_prev1_reg;
    logic signed [SW-1:0]               crushed_prev2_reg;
    logic signed [HW-1:0]               filtered_prev1_reg;
    logic signed [HW-1:0]               filtered_prev2_reg;

    // Working registers.
    state_t                             state_reg;
    logic signed [SW-1:0]               x_reg;
    logic [SW-1:0]                      rom_reg;
    logic                               ring_sign_reg;
    logic [rvae_pkg::RING_W-1:0]        ring_acc_reg;
    logic [rvae_pkg::RING_W-1:0]        ring_mcand_reg;
    logic signed [SW-1:0]               crushed_reg;
    logic signed [AW-1:0]               acc_reg;
    logic signed [AW-1:0]               mcand_reg;
    logic [rvae_pkg::MUL_W-1:0]         mulr_reg;
    logic [rvae_pkg::CNT_W-1:0]         cnt_reg;
    logic [rvae_pkg::CNT_W-1:0]         len_reg;
    logic                               neg_reg;
    logic [1:0]                         prod_reg;
    logic [SW-1:0]                      result_reg;
    logic                               out_valid_reg;
    logic [SW-1:0]                      out_data_reg;

    logic                               in_xfer;
    logic                               cfg_xfer;
    logic                               cfg_known;
    logic                               out_load;

    // Carrier lookup.
    logic [1:0]                         quadrant;
    logic [rvae_pkg::SINE_ABITS-1:0]    rom_k;
    logic [rvae_pkg::SINE_ABITS:0]      rom_addr;
    logic [SW-1:0]                      carrier_mag;
    logic                               carrier_sign;
    logic [SW-1:0]                      x_mag;

    // Crusher.
    logic [rvae_pkg::CRUSH_W-1:0]       crush_b;
    logic [31:0]                        crush_rnd;
    logic [31:0]                        crush_keep;
    logic [31:0]                        crush_sum;
    logic [SW:0]                        crush_mag;
    logic [SW:0]                        crush_neg;
    logic signed [SW-1:0]               crushed_next;

    // Filter.
    logic signed [rvae_pkg::DIFF_BITS-1:0] diff;
    logic                               mac_last;
    logic                               mac_sub;
    logic signed [AW-1:0]               acc_next;
    logic signed [AW-1:0]               round_sum;
    logic signed [AW-1:0]               round_shift;
    logic signed [HW-1:0]               y_next;
    logic [SW-1:0]                      y_out;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_xfer      = cfg_valid && cfg_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A finished result moves to the output register once that register is
    // empty or its current transfer happens in the same cycle.
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        case (cfg_index)
            rvae_pkg::CFG_PHASE_STEP,
            rvae_pkg::CFG_SQUARE,
            rvae_pkg::CFG_CRUSH_BITS,
            rvae_pkg::CFG_COEF_B0,
            rvae_pkg::CFG_COEF_A1,
            rvae_pkg::CFG_COEF_A2,
            rvae_pkg::CFG_BYPASS:   cfg_known = 1'b1;
            default:                cfg_known = 1'b0;
        endcase
    end

    // The top two phase bits pick the quadrant, the next bits the table entry.
    // Odd quadrants run the table backward, the second half negates it.
    always_comb
    begin
        quadrant = phase_reg[rvae_pkg::PHASE_BITS-1 -: 2];
        rom_k    = phase_reg[rvae_pkg::PHASE_BITS-3 -: rvae_pkg::SINE_ABITS];
        if (quadrant[0])
        begin
            rom_addr = (rvae_pkg::SINE_ABITS + 1)'(rvae_pkg::SINE_DEPTH) - {1'b0, rom_k};
        end
        else
        begin
            rom_addr = {1'b0, rom_k};
        end
        if (square_reg)
        begin
            carrier_mag  = FULL_SCALE;
            carrier_sign = phase_reg[rvae_pkg::PHASE_BITS-1];
        end
        else
        begin
            carrier_mag  = rom_reg;
            carrier_sign = quadrant[1];
        end
        x_mag = x_reg[SW-1] ? SW'(-x_reg) : SW'(x_reg);
    end

    // Rounding half away from zero works on the magnitude: add half of the
    // lowest kept step, then clear everything below it.
    always_comb
    begin
        if (crush_bits_reg < rvae_pkg::CRUSH_MIN)
        begin
            crush_b = rvae_pkg::CRUSH_MIN;
        end
        else if (crush_bits_reg > rvae_pkg::CRUSH_MAX)
        begin
            crush_b = rvae_pkg::CRUSH_MAX;
        end
        else
        begin
            crush_b = crush_bits_reg;
        end
        crush_rnd  = 32'd1 << (5'd30 - crush_b);
        crush_keep = ~((32'd1 << (5'd31 - crush_b)) - 32'd1);
        crush_sum  = ({1'b0, ring_acc_reg} + crush_rnd) & crush_keep;
        crush_mag  = crush_sum[31:15];
        crush_neg  = -crush_mag;
        if (ring_sign_reg)
        begin
            crushed_next = crush_neg[SW-1:0];
        end
        else if (crush_mag > (SW + 1)'(OUT_MAX))
        begin
            crushed_next = OUT_MAX[SW-1:0];
        end
        else
        begin
            crushed_next = crush_mag[SW-1:0];
        end
    end

    // One multiplier bit per clock. The top bit of a two's complement
    // multiplier weighs negative; a negated product flips add and subtract.
    always_comb
    begin
        diff     = rvae_pkg::DIFF_BITS'(crushed_reg) - rvae_pkg::DIFF_BITS'(crushed_prev2_reg);
        mac_last = (cnt_reg == len_reg - rvae_pkg::CNT_W'(1));
        mac_sub  = mac_last ^ neg_reg;
        if (!mulr_reg[0])
        begin
            acc_next = acc_reg;
        end
        else if (mac_sub)
        begin
            acc_next = acc_reg - mcand_reg;
        end
        else
        begin
            acc_next = acc_reg + mcand_reg;
        end
    end

    // Round half up to 15 fraction bits, then saturate to the history width
    // and again to the output width.
    always_comb
    begin
        round_sum   = acc_reg + ROUND_HALF;
        round_shift = round_sum >>> 16;
        if (round_shift > HIST_MAX)
        begin
            y_next = HIST_MAX[HW-1:0];
        end
        else if (round_shift < HIST_MIN)
        begin
            y_next = HIST_MIN[HW-1:0];
        end
        else
        begin
            y_next = round_shift[HW-1:0];
        end
        if (y_next > OUT_MAX)
        begin
            y_out = OUT_MAX[SW-1:0];
        end
        else if (y_next < OUT_MIN)
        begin
            y_out = OUT_MIN[SW-1:0];
        end
        else
        begin
            y_out = y_next[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg     <= rvae_pkg::RST_PHASE_STEP;
            square_reg         <= rvae_pkg::RST_SQUARE;
            crush_bits_reg     <= rvae_pkg::RST_CRUSH_BITS;
            coef_b0_reg        <= '0;
            coef_a1_reg        <= '0;
            coef_a2_reg        <= '0;
            bypass_reg         <= rvae_pkg::RST_BYPASS;
            phase_reg          <= '0;
            crushed_prev1_reg  <= '0;
            crushed_prev2_reg  <= '0;
            filtered_prev1_reg <= '0;
            filtered_prev2_reg <= '0;
            state_reg          <= ST_IDLE;
            x_reg              <= '0;
            rom_reg            <= '0;
            ring_sign_reg      <= 1'b0;
            ring_acc_reg       <= '0;
            ring_mcand_reg     <= '0;
            crushed_reg        <= '0;
            acc_reg            <= '0;
            mcand_reg          <= '0;
            mulr_reg           <= '0;
            cnt_reg            <= '0;
            len_reg            <= '0;
            neg_reg            <= 1'b0;
            prod_reg           <= '0;
            result_reg         <= '0;
            out_valid_reg      <= 1'b0;
            out_data_reg       <= '0;
        end
        else
        begin
            if (cfg_xfer)
            begin
                case (cfg_index)
                    rvae_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data[rvae_pkg::STEP_W-1:0];
                    rvae_pkg::CFG_SQUARE:     square_reg     <= cfg_data[0];
                    rvae_pkg::CFG_CRUSH_BITS: crush_bits_reg <= cfg_data[rvae_pkg::CRUSH_W-1:0];
                    rvae_pkg::CFG_COEF_B0:    coef_b0_reg    <= cfg_data[rvae_pkg::COEF_W-1:0];
                    rvae_pkg::CFG_COEF_A1:    coef_a1_reg    <= cfg_data[rvae_pkg::COEF_W-1:0];
                    rvae_pkg::CFG_COEF_A2:    coef_a2_reg    <= cfg_data[rvae_pkg::COEF_W-1:0];
                    rvae_pkg::CFG_BYPASS:     bypass_reg     <= cfg_data[0];
                    default:                  ;
                endcase
                if (cfg_known)
                begin
                    crushed_prev1_reg  <= '0;
                    crushed_prev2_reg  <= '0;
                    filtered_prev1_reg <= '0;
                    filtered_prev2_reg <= '0;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= result_reg;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        x_reg      <= s_axis_tdata;
                        result_reg <= s_axis_tdata;
                        if (bypass_reg)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            phase_reg <= phase_reg + rvae_pkg::PHASE_BITS'(phase_step_reg);
                            state_reg <= ST_CARRIER;
                        end
                    end
                end
                ST_CARRIER:
                begin
                    rom_reg   <= rvae_pkg::SINE_ROM[rom_addr];
                    state_reg <= ST_LOAD_RING;
                end
                ST_LOAD_RING:
                begin
                    ring_sign_reg  <= x_reg[SW-1] ^ carrier_sign;
                    ring_acc_reg   <= '0;
                    ring_mcand_reg <= rvae_pkg::RING_W'(x_mag);
                    mulr_reg       <= rvae_pkg::MUL_W'(carrier_mag);
                    cnt_reg        <= '0;
                    state_reg      <= ST_RING;
                end
                ST_RING:
                begin
                    if (mulr_reg[0])
                    begin
                        ring_acc_reg <= ring_acc_reg + ring_mcand_reg;
                    end
                    ring_mcand_reg <= ring_mcand_reg << 1;
                    mulr_reg       <= mulr_reg >> 1;
                    cnt_reg        <= cnt_reg + rvae_pkg::CNT_W'(1);
                    if (cnt_reg == rvae_pkg::CNT_W'(rvae_pkg::RING_BITS - 1))
                    begin
                        state_reg <= ST_CRUSH;
                    end
                end
                ST_CRUSH:
                begin
                    crushed_reg <= crushed_next;
                    acc_reg     <= '0;
                    prod_reg    <= 2'd0;
                    state_reg   <= ST_LOAD_MAC;
                end
                ST_LOAD_MAC:
                begin
                    cnt_reg <= '0;
                    case (prod_reg)
                        2'd0:
                        begin
                            mcand_reg <= AW'(coef_b0_reg);
                            mulr_reg  <= rvae_pkg::MUL_W'(diff);
                            len_reg   <= rvae_pkg::CNT_W'(rvae_pkg::DIFF_BITS);
                            neg_reg   <= 1'b0;
                        end
                        2'd1:
                        begin
                            mcand_reg <= AW'(coef_a1_reg);
                            mulr_reg  <= filtered_prev1_reg;
                            len_reg   <= rvae_pkg::CNT_W'(HW);
                            neg_reg   <= 1'b1;
                        end
                        default:
                        begin
                            mcand_reg <= AW'(coef_a2_reg);
                            mulr_reg  <= filtered_prev2_reg;
                            len_reg   <= rvae_pkg::CNT_W'(HW);
                            neg_reg   <= 1'b1;
                        end
                    endcase
                    state_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    acc_reg   <= acc_next;
                    mcand_reg <= mcand_reg <<< 1;
                    mulr_reg  <= mulr_reg >> 1;
                    cnt_reg   <= cnt_reg + rvae_pkg::CNT_W'(1);
                    if (mac_last)
                    begin
                        if (prod_reg == 2'd2)
                        begin
                            state_reg <= ST_ROUND;
                        end
                        else
                        begin
                            prod_reg  <= prod_reg + 2'd1;
                            state_reg <= ST_LOAD_MAC;
                        end
                    end
                end
                ST_ROUND:
                begin
                    result_reg         <= y_out;
                    crushed_prev2_reg  <= crushed_prev1_reg;
                    crushed_prev1_reg  <= crushed_reg;
                    filtered_prev2_reg <= filtered_prev1_reg;
                    filtered_prev1_reg <= y_next;
                    state_reg          <= ST_DONE;
                end
                ST_DONE:
                begin
                    // Wait here while the previous result is still unclaimed.
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/robot_voice_audio_effect_top_tb.sv @@
`timescale 1ns / 1ps

// Predicts the robot-voice effect one sample at a time and compares every
// result that leaves the block against the oldest prediction.
class robot_voice_scoreboard;

    // Configuration copy; the step and the depth keep the widths of the block's registers.
    logic [rvae_pkg::STEP_W-1:0]     step_cfg;
    bit                              square_on;
    logic [rvae_pkg::CRUSH_W-1:0]    crush_cfg;
    longint                          b0;
    longint                          a1;
    longint                          a2;
    bit                              bypass_on;

    // Carrier phase and the two-deep filter history.
    logic [rvae_pkg::PHASE_BITS-1:0] phase;
    longint                          crushed_prev1;
    longint                          crushed_prev2;
    longint                          filtered_prev1;
    longint                          filtered_prev2;

    longint                          sine_tab [0:rvae_pkg::SINE_DEPTH];
    logic [rvae_pkg::SAMPLE_W-1:0]   predicted_samples [$];
    int                              errors;

    function new();
        longint unsigned theta;
        longint unsigned term;
        longint unsigned half_pi;
        longint          sum;
        int              k;
        int              n;
        // Quarter-wave sine in Q30 by a nine-term Taylor series, rounded to Q15.
        half_pi = 64'd1686629713;
        for (k = 0; k <= rvae_pkg::SINE_DEPTH; k++)
        begin
            theta = (half_pi * longint'(k)) / rvae_pkg::SINE_DEPTH;
            term  = theta;
            sum   = longint'(theta);
            for (n = 1; n <= 8; n++)
            begin
                term = (term * theta) >> 30;
                term = (term * theta) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            sine_tab[k] = clamp((sum + 16384) >>> 15, 0, 32768);
        end
        errors    = 0;
        step_cfg  = rvae_pkg::RST_PHASE_STEP;
        square_on = rvae_pkg::RST_SQUARE;
        crush_cfg = rvae_pkg::RST_CRUSH_BITS;
        b0        = 0;
        a1        = 0;
        a2        = 0;
        bypass_on = rvae_pkg::RST_BYPASS;
        phase     = '0;
        clear_history();
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function void clear_history();
        crushed_prev1  = 0;
        crushed_prev2  = 0;
        filtered_prev1 = 0;
        filtered_prev2 = 0;
    endfunction

    function int pending();
        return predicted_samples.size();
    endfunction

    // A write to a defined register clears the filter history; the phase stays.
    function void write_reg(logic [rvae_pkg::CFG_INDEX_W-1:0] idx,
                            logic [rvae_pkg::CFG_DATA_W-1:0] value);
        logic signed [rvae_pkg::COEF_W-1:0] coef;
        coef = value[rvae_pkg::COEF_W-1:0];
        case (idx)
            rvae_pkg::CFG_PHASE_STEP: step_cfg  = value[rvae_pkg::STEP_W-1:0];
            rvae_pkg::CFG_SQUARE:     square_on = value[0];
            rvae_pkg::CFG_CRUSH_BITS: crush_cfg = value[rvae_pkg::CRUSH_W-1:0];
            rvae_pkg::CFG_COEF_B0:    b0        = coef;
            rvae_pkg::CFG_COEF_A1:    a1        = coef;
            rvae_pkg::CFG_COEF_A2:    a2        = coef;
            rvae_pkg::CFG_BYPASS:     bypass_on = value[0];
            default:                  return;
        endcase
        clear_history();
    endfunction

    function void note_sample(logic [rvae_pkg::SAMPLE_W-1:0] s);
        logic signed [rvae_pkg::SAMPLE_W-1:0] xs;
        longint          x;
        longint          carrier;
        longint          v;
        longint          prod;
        longint          mag;
        longint          r;
        longint          one;
        longint          crushed;
        longint          acc;
        longint          y;
        longint unsigned idx;
        int              q;
        int              k;
        int              b;
        xs  = s;
        x   = xs;
        one = 1;
        if (bypass_on)
        begin
            predicted_samples.push_back(s);
            return;
        end
        phase = phase + step_cfg;
        if (square_on)
        begin
            carrier = phase[rvae_pkg::PHASE_BITS-1] ? -32768 : 32768;
        end
        else
        begin
            idx = (longint'(phase) * 4 * rvae_pkg::SINE_DEPTH) >> rvae_pkg::PHASE_BITS;
            q   = int'((idx / rvae_pkg::SINE_DEPTH) % 4);
            k   = int'(idx % rvae_pkg::SINE_DEPTH);
            v   = ((q % 2) == 1) ? sine_tab[rvae_pkg::SINE_DEPTH - k] : sine_tab[k];
            carrier = (q >= 2) ? -v : v;
        end
        prod = x * carrier;
        // Out-of-range depths act as the nearest limit.
        b = int'(crush_cfg);
        if (b < int'(rvae_pkg::CRUSH_MIN))
        begin
            b = int'(rvae_pkg::CRUSH_MIN);
        end
        if (b > int'(rvae_pkg::CRUSH_MAX))
        begin
            b = int'(rvae_pkg::CRUSH_MAX);
        end
        // Round half away from zero on the magnitude, then restore the sign.
        mag     = (prod < 0) ? -prod : prod;
        r       = (mag + (one << (30 - b))) >> (31 - b);
        r       = r << (16 - b);
        crushed = clamp((prod < 0) ? -r : r, -32768, 32767);
        acc = b0 * crushed - b0 * crushed_prev2 - a1 * filtered_prev1 - a2 * filtered_prev2;
        y   = (acc + 32768) >>> 16;
        y   = clamp(y, -(one << (rvae_pkg::HIST_W - 1)), (one << (rvae_pkg::HIST_W - 1)) - 1);
        crushed_prev2  = crushed_prev1;
        crushed_prev1  = crushed;
        filtered_prev2 = filtered_prev1;
        filtered_prev1 = y;
        predicted_samples.push_back(rvae_pkg::SAMPLE_W'(clamp(y, -32768, 32767)));
    endfunction

    function void check_sample(logic [rvae_pkg::SAMPLE_W-1:0] got);
        logic [rvae_pkg::SAMPLE_W-1:0] want;
        if (predicted_samples.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected sample_out, expected none, actual %0d",
                     $time, $signed(got));
            return;
        end
        want = predicted_samples.pop_front();
        if (got !== want)
        begin
            errors++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, $signed(want), $signed(got));
        end
    endfunction

endclass

module robot_voice_audio_effect_top_tb;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [rvae_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    // Rough counts for the random part, the long output hold-off and the tail.
    localparam int RANDOM_ITEMS = 1150;
    localparam int HOLD_CYCLES  = 1000;
    localparam int HOLD_PHASE   = 4;
    localparam int TAIL_CYCLES  = 120;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [rvae_pkg::SAMPLE_W-1:0]     s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [rvae_pkg::SAMPLE_W-1:0]     m_axis_tdata;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [rvae_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [rvae_pkg::CFG_DATA_W-1:0]   cfg_data;

    robot_voice_scoreboard   sb;

    // The sender skips its idle gaps while this is set.
    bit                      no_gaps;
    // Raised by the stimulus to ask the result side for one long hold-off.
    bit                      hold_output;

    robot_voice_audio_effect_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit: several times the slowest correct run.
    initial
    begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    // Offers one sample, after a random idle gap, and holds it until the
    // transfer. The valid is left high afterwards so that back-to-back samples
    // never see a low and a high scheduled in the same time step.
    task automatic send_sample(input logic [rvae_pkg::SAMPLE_W-1:0] s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= s;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_sample(s);
    endtask

    // One register write. The valid drops after the transfer in a step of its
    // own, before the task returns.
    task automatic cfg_write(input logic [rvae_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rvae_pkg::CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering samples, wait until every predicted result has come back,
    // and then let the clock run on so the block is idle for a register write.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Bits above a register's width are ignored by the block, so half of the
    // writes put noise there.
    function automatic logic [rvae_pkg::CFG_DATA_W-1:0] with_noise(
        input logic [rvae_pkg::CFG_DATA_W-1:0] v,
        input int w);
        logic [rvae_pkg::CFG_DATA_W-1:0] mask;
        logic [rvae_pkg::CFG_DATA_W-1:0] noise;
        mask  = (rvae_pkg::CFG_DATA_W'(1) << w) - rvae_pkg::CFG_DATA_W'(1);
        noise = rvae_pkg::CFG_DATA_W'($urandom);
        if ($urandom_range(0, 1) == 1)
        begin
            return (v & mask) | (noise & ~mask);
        end
        return v & mask;
    endfunction

    function automatic logic [rvae_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return rvae_pkg::SAMPLE_W'($urandom_range(0, 3)) - rvae_pkg::SAMPLE_W'(2);
            default: return rvae_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [rvae_pkg::CFG_DATA_W-1:0] random_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return rvae_pkg::CFG_DATA_W'(8388608);
            2:       return '1;
            3:       return rvae_pkg::CFG_DATA_W'($urandom);
            default: return rvae_pkg::CFG_DATA_W'($urandom_range(500, 600000));
        endcase
    endfunction

    // Picks a new setting for a random phase; writes a random subset of the
    // registers, always the bypass, and now and then the unused index.
    task automatic program_random_setting();
        int lim;
        int c_b0;
        int c_a1;
        int c_a2;
        if ($urandom_range(0, 1) == 1)
        begin
            cfg_write(rvae_pkg::CFG_PHASE_STEP, with_noise(random_step(), rvae_pkg::STEP_W));
        end
        if ($urandom_range(0, 1) == 1)
        begin
            cfg_write(rvae_pkg::CFG_SQUARE,
                      with_noise(rvae_pkg::CFG_DATA_W'($urandom_range(0, 1)), 1));
        end
        if ($urandom_range(0, 1) == 1)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                cfg_write(rvae_pkg::CFG_CRUSH_BITS,
                          with_noise(rvae_pkg::CFG_DATA_W'($urandom_range(0, 31)),
                                     rvae_pkg::CRUSH_W));
            end
            else
            begin
                cfg_write(rvae_pkg::CFG_CRUSH_BITS,
                          with_noise(rvae_pkg::CFG_DATA_W'($urandom_range(4, 16)),
                                     rvae_pkg::CRUSH_W));
            end
        end
        if ($urandom_range(0, 1) == 1)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                // A stable bandpass keeps the output off the rails most of the time.
                c_a2 = $urandom_range(0, 62000);
                lim  = 65536 + c_a2 - 1500;
                c_a1 = $urandom_range(0, 2 * lim) - lim;
                c_b0 = $urandom_range(0, 80000) - 40000;
            end
            else
            begin
                c_b0 = $urandom_range(0, 524287) - 262144;
                c_a1 = $urandom_range(0, 524287) - 262144;
                c_a2 = $urandom_range(0, 524287) - 262144;
            end
            cfg_write(rvae_pkg::CFG_COEF_B0,
                      with_noise(rvae_pkg::CFG_DATA_W'(c_b0), rvae_pkg::COEF_W));
            cfg_write(rvae_pkg::CFG_COEF_A1,
                      with_noise(rvae_pkg::CFG_DATA_W'(c_a1), rvae_pkg::COEF_W));
            cfg_write(rvae_pkg::CFG_COEF_A2,
                      with_noise(rvae_pkg::CFG_DATA_W'(c_a2), rvae_pkg::COEF_W));
        end
        cfg_write(rvae_pkg::CFG_BYPASS,
                  with_noise(rvae_pkg::CFG_DATA_W'($urandom_range(0, 5) == 0), 1));
        if ($urandom_range(0, 3) == 0)
        begin
            cfg_write(CFG_UNUSED, rvae_pkg::CFG_DATA_W'($urandom));
        end
    endtask

    // Result side: accepts one result per loop after its own random gap, with
    // occasional stretches of no gaps and one long hold-off on request.
    initial
    begin : result_sink
        int gap;
        bit burst;
        burst = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_output)
            begin
                // Long stall, counted here, while the sender keeps offering
                // samples; the block fills up and must stall its input.
                hold_output = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 31) == 0)
            begin
                burst = !burst;
            end
            gap = burst ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            sb.check_sample(m_axis_tdata);
        end
    end

    initial
    begin : stimulus
        int sent;
        int phase_no;
        int count;
        sb          = new();
        no_gaps     = 1'b0;
        hold_output = 1'b0;
        sent        = 0;
        phase_no    = 0;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the block is in bypass: samples come back unchanged.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        drain();

        // Every register written. A half-cycle step flips the square carrier
        // each sample; a unity b0 with no feedback shows the crushed value
        // minus the one from two samples back.
        cfg_write(rvae_pkg::CFG_PHASE_STEP, rvae_pkg::CFG_DATA_W'(8388608));
        cfg_write(rvae_pkg::CFG_SQUARE, rvae_pkg::CFG_DATA_W'(1));
        cfg_write(rvae_pkg::CFG_CRUSH_BITS, rvae_pkg::CFG_DATA_W'(16));
        cfg_write(rvae_pkg::CFG_COEF_B0, rvae_pkg::CFG_DATA_W'(65536));
        cfg_write(rvae_pkg::CFG_COEF_A1, rvae_pkg::CFG_DATA_W'(0));
        cfg_write(rvae_pkg::CFG_COEF_A2, rvae_pkg::CFG_DATA_W'(0));
        cfg_write(rvae_pkg::CFG_BYPASS, rvae_pkg::CFG_DATA_W'(0));
        // The first sample meets a negative carrier: a full-scale negative
        // sample gives a product of exactly +1.0, which has to saturate.
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        drain();

        // Extreme coefficients drive the 24-bit history into saturation.
        cfg_write(rvae_pkg::CFG_COEF_B0, rvae_pkg::CFG_DATA_W'(262143));
        cfg_write(rvae_pkg::CFG_COEF_A1, rvae_pkg::CFG_DATA_W'(-262144));
        cfg_write(rvae_pkg::CFG_COEF_A2, rvae_pkg::CFG_DATA_W'(262143));
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h3039);
        drain();

        // A write to the unused index must leave the history untouched.
        cfg_write(CFG_UNUSED, rvae_pkg::CFG_DATA_W'($urandom));
        send_sample(16'h8000);
        send_sample(16'h1234);
        send_sample(16'hEDCC);
        drain();

        // Sine carrier with a depth below the limit, then one above it.
        cfg_write(rvae_pkg::CFG_SQUARE, rvae_pkg::CFG_DATA_W'(0));
        cfg_write(rvae_pkg::CFG_PHASE_STEP, rvae_pkg::CFG_DATA_W'(24'hFFFFFF));
        cfg_write(rvae_pkg::CFG_COEF_B0, rvae_pkg::CFG_DATA_W'(65536));
        cfg_write(rvae_pkg::CFG_COEF_A1, rvae_pkg::CFG_DATA_W'(0));
        cfg_write(rvae_pkg::CFG_COEF_A2, rvae_pkg::CFG_DATA_W'(0));
        cfg_write(rvae_pkg::CFG_CRUSH_BITS, rvae_pkg::CFG_DATA_W'(0));
        send_sample(16'h4E20);
        send_sample(16'hB1E0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();
        cfg_write(rvae_pkg::CFG_PHASE_STEP, rvae_pkg::CFG_DATA_W'(3000000));
        cfg_write(rvae_pkg::CFG_CRUSH_BITS, rvae_pkg::CFG_DATA_W'(31));
        send_sample(16'h7FFF);
        send_sample(16'h8001);
        send_sample(16'h2AAA);
        drain();

        // Random phases, each with a fresh setting written while idle.
        while (sent < RANDOM_ITEMS)
        begin
            program_random_setting();
            no_gaps = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(20, 80);
            if (phase_no == HOLD_PHASE)
            begin
                no_gaps     = 1'b1;
                count       = 40;
                hold_output = 1'b1;
            end
            repeat (count)
            begin
                send_sample(random_sample());
                sent++;
            end
            drain();
            phase_no++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected samples never arrived", $time, sb.pending());
        end
        if ((sb.errors == 0) && (sb.pending() == 0))
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
